### rtl/lspd_pkg.sv
`timescale 1ns / 1ps
// Package for the length/sequence packet deframer.
// Holds word and result types, operation and result kind codes and fixed limits; no dependencies.
package lspd_pkg;

  localparam logic [23:0] FRAGMENT_MAX       = 24'd16777215;
  localparam logic [29:0] HARD_MESSAGE_LIMIT = 30'd1073741823;
  localparam logic [30:0] MAX_MSG_RESET      = 31'd67108864;

  localparam logic OP_LINK_BYTE = 1'b0;
  localparam logic OP_SET_SEQ   = 1'b1;

  typedef enum logic [2:0] {
    KIND_PAYLOAD      = 3'd0,
    KIND_EMPTY_END    = 3'd1,
    KIND_SEQ_MISMATCH = 3'd2,
    KIND_HARD_LARGE   = 3'd3,
    KIND_OVER_LIMIT   = 3'd4
  } kind_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] link_byte;
    logic [7:0] new_sequence;
  } item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic        last;
    logic [29:0] message_length;
    logic [7:0]  next_sequence;
    logic [7:0]  received_sequence;
  } result_t;

endpackage

### rtl/lspd_in_stage.sv
`timescale 1ns / 1ps
// Input register for the deframer: holds one accepted word until processed.
// Uses lspd_pkg::item_t.
module lspd_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  lspd_pkg::item_t in_item_i,
  input  logic          go_i,
  output logic          in_stall_o,
  output logic          valid_o,
  output lspd_pkg::item_t item_o
);

  logic            valid_q;
  lspd_pkg::item_t item_q;
  logic            load;

  assign in_stall_o = valid_q & ~go_i;
  assign load       = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (go_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### rtl/lspd_frame_ctrl.sv
`timescale 1ns / 1ps
// Framing state and per-word step logic: header assembly, sequence and size checks,
// payload countdown. Uses lspd_pkg types and constants.
module lspd_frame_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [30:0]      cfg_wdata_i,
  input  logic             go_i,
  input  lspd_pkg::item_t  item_i,
  output logic             has_result_o,
  output lspd_pkg::result_t result_o
);

  logic [30:0] max_msg_q;
  logic [1:0]  hdr_pos_q, hdr_pos_d;
  logic [23:0] frag_len_q, frag_len_d;
  logic [7:0]  exp_seq_q, exp_seq_d;
  logic [23:0] remain_q, remain_d;
  logic        in_payload_q, in_payload_d;
  logic        final_q, final_d;
  logic [29:0] total_q, total_d;
  logic        halted_q, halted_d;

  logic [23:0] remain_dec;
  logic [23:0] frag_merged;
  logic [30:0] sum;
  logic [7:0]  seq_inc;

  assign remain_dec = remain_q - 24'd1;
  assign sum        = {1'b0, total_q} + {7'd0, frag_len_q};
  assign seq_inc    = exp_seq_q + 8'd1;

  always_comb begin
    frag_merged = frag_len_q;
    case (hdr_pos_q)
      2'd0:    frag_merged[7:0]   = frag_len_q[7:0]   | item_i.link_byte;
      2'd1:    frag_merged[15:8]  = frag_len_q[15:8]  | item_i.link_byte;
      2'd2:    frag_merged[23:16] = frag_len_q[23:16] | item_i.link_byte;
      default: frag_merged = frag_len_q;
    endcase
  end

  always_comb begin
    hdr_pos_d    = hdr_pos_q;
    frag_len_d   = frag_len_q;
    exp_seq_d    = exp_seq_q;
    remain_d     = remain_q;
    in_payload_d = in_payload_q;
    final_d      = final_q;
    total_d      = total_q;
    halted_d     = halted_q;
    has_result_o = 1'b0;
    result_o     = '0;

    if (item_i.operation == lspd_pkg::OP_SET_SEQ) begin
      exp_seq_d    = item_i.new_sequence;
      halted_d     = 1'b0;
      hdr_pos_d    = 2'd0;
      frag_len_d   = '0;
      remain_d     = '0;
      in_payload_d = 1'b0;
      final_d      = 1'b0;
      total_d      = '0;
    end else if (!halted_q) begin
      if (in_payload_q) begin
        has_result_o       = 1'b1;
        result_o.kind      = lspd_pkg::KIND_PAYLOAD;
        result_o.data_byte = item_i.link_byte;
        remain_d           = remain_dec;
        if (remain_dec == 24'd0) begin
          in_payload_d = 1'b0;
          hdr_pos_d    = 2'd0;
          frag_len_d   = '0;
          if (final_q) begin
            result_o.last           = 1'b1;
            result_o.message_length = total_q;
            total_d                 = '0;
          end
        end
      end else if (hdr_pos_q != 2'd3) begin
        frag_len_d = frag_merged;
        hdr_pos_d  = hdr_pos_q + 2'd1;
      end else begin
        // sequence byte closes the header
        hdr_pos_d = 2'd0;
        if (item_i.link_byte != exp_seq_q) begin
          halted_d                   = 1'b1;
          has_result_o               = 1'b1;
          result_o.kind              = lspd_pkg::KIND_SEQ_MISMATCH;
          result_o.received_sequence = item_i.link_byte;
        end else begin
          exp_seq_d  = seq_inc;
          frag_len_d = '0;
          if (sum > {1'b0, lspd_pkg::HARD_MESSAGE_LIMIT}) begin
            halted_d      = 1'b1;
            has_result_o  = 1'b1;
            result_o.kind = lspd_pkg::KIND_HARD_LARGE;
          end else if (sum > max_msg_q) begin
            halted_d      = 1'b1;
            has_result_o  = 1'b1;
            result_o.kind = lspd_pkg::KIND_OVER_LIMIT;
          end else begin
            total_d = sum[29:0];
            final_d = frag_len_q < lspd_pkg::FRAGMENT_MAX;
            if (frag_len_q == 24'd0) begin
              if (frag_len_q < lspd_pkg::FRAGMENT_MAX) begin
                has_result_o            = 1'b1;
                result_o.kind           = lspd_pkg::KIND_EMPTY_END;
                result_o.last           = 1'b1;
                result_o.message_length = sum[29:0];
                total_d                 = '0;
              end
            end else begin
              in_payload_d = 1'b1;
              remain_d     = frag_len_q;
            end
          end
        end
      end
    end
    result_o.next_sequence = exp_seq_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_msg_q    <= lspd_pkg::MAX_MSG_RESET;
      hdr_pos_q    <= 2'd0;
      frag_len_q   <= '0;
      exp_seq_q    <= '0;
      remain_q     <= '0;
      in_payload_q <= 1'b0;
      final_q      <= 1'b0;
      total_q      <= '0;
      halted_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_msg_q <= cfg_wdata_i;
      end
      if (go_i) begin
        hdr_pos_q    <= hdr_pos_d;
        frag_len_q   <= frag_len_d;
        exp_seq_q    <= exp_seq_d;
        remain_q     <= remain_d;
        in_payload_q <= in_payload_d;
        final_q      <= final_d;
        total_q      <= total_d;
        halted_q     <= halted_d;
      end
    end
  end

endmodule

### rtl/lspd_out_stage.sv
`timescale 1ns / 1ps
// Result register for the deframer: one result word held until taken downstream.
// Uses lspd_pkg::result_t.
module lspd_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  lspd_pkg::result_t result_i,
  input  logic              out_stall_i,
  output logic              ready_o,
  output logic              out_valid_o,
  output lspd_pkg::result_t result_o
);

  logic              valid_q;
  lspd_pkg::result_t result_q;

  assign ready_o = ~valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

### rtl/length_seq_packet_deframer_unit.sv
`timescale 1ns / 1ps
// Length/sequence packet deframer, top level. Depends on lspd_pkg, lspd_in_stage,
// lspd_frame_ctrl and lspd_out_stage.
// Path: input reg, then result reg; a word with a result waits while output is blocked.
// Throughput: one word per cycle when not stalled; a word with no result never waits.
// Reset (rst_ni low, async): empty stages, framing cleared, expected sequence 0,
// limit register 67108864.
module length_seq_packet_deframer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [7:0]  link_byte_i,
  input  logic [7:0]  new_sequence_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic        last_o,
  output logic [29:0] message_length_o,
  output logic [7:0]  next_sequence_o,
  output logic [7:0]  received_sequence_o,
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i
);

  lspd_pkg::item_t   in_item;
  lspd_pkg::item_t   item_q;
  lspd_pkg::result_t step_res;
  lspd_pkg::result_t out_res;
  logic              item_valid;
  logic              has_result;
  logic              out_ready;
  logic              go;

  assign in_item.operation    = operation_i;
  assign in_item.link_byte    = link_byte_i;
  assign in_item.new_sequence = new_sequence_i;

  // word leaves the input reg unless it has a result and the output is blocked
  assign go = item_valid & (~has_result | out_ready);

  lspd_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item),
    .go_i       (go),
    .in_stall_o (in_stall_o),
    .valid_o    (item_valid),
    .item_o     (item_q)
  );

  lspd_frame_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .go_i         (go),
    .item_i       (item_q),
    .has_result_o (has_result),
    .result_o     (step_res)
  );

  lspd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (go & has_result),
    .result_i    (step_res),
    .out_stall_i (out_stall_i),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .result_o    (out_res)
  );

  assign kind_o              = 3'(out_res.kind);
  assign data_byte_o         = out_res.data_byte;
  assign last_o              = out_res.last;
  assign message_length_o    = out_res.message_length;
  assign next_sequence_o     = out_res.next_sequence;
  assign received_sequence_o = out_res.received_sequence;

endmodule

### rtl/lspd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the deframer top level, attached by bind.
// Depends on lspd_pkg and length_seq_packet_deframer_unit.
module lspd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  kind_o,
  input logic [7:0]  data_byte_o,
  input logic        last_o,
  input logic [29:0] message_length_o,
  input logic [7:0]  next_sequence_o,
  input logic [7:0]  received_sequence_o
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(data_byte_o)
      && $stable(last_o) && $stable(message_length_o) && $stable(next_sequence_o))
    else $error("result word changed while stalled");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> kind_o == 3'(lspd_pkg::KIND_PAYLOAD)
      || kind_o == 3'(lspd_pkg::KIND_EMPTY_END))
    else $error("error word marked last");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == 3'(lspd_pkg::KIND_EMPTY_END) |-> last_o)
    else $error("empty message end without last");

  a_len_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> message_length_o == 30'd0)
    else $error("message length on non-last word");

  a_rx_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != 3'(lspd_pkg::KIND_SEQ_MISMATCH) |-> received_sequence_o == 8'd0)
    else $error("received sequence outside mismatch");

endmodule

bind length_seq_packet_deframer_unit lspd_checker u_lspd_checker (.*);

### bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for length_seq_packet_deframer_unit; needs lspd_pkg and the RTL only.
// Framed link words go in, each result word is predicted and compared in order of arrival.
module testbench;

  class deframer_scoreboard;
    logic [30:0] size_limit;
    logic [1:0]  hdr_pos;
    logic [23:0] frag_len;
    logic [23:0] bytes_left;
    logic [7:0]  exp_seq;
    logic [29:0] msg_total;
    bit          in_payload;
    bit          final_frag;
    bit          halted;
    lspd_pkg::result_t due_results[$];
    int          fail_count;

    function new();
      size_limit = lspd_pkg::MAX_MSG_RESET;
      exp_seq    = '0;
      halted     = 1'b0;
      fail_count = 0;
      clear_framing();
    endfunction

    function void clear_framing();
      hdr_pos    = '0;
      frag_len   = '0;
      bytes_left = '0;
      in_payload = 1'b0;
      final_frag = 1'b0;
      msg_total  = '0;
    endfunction

    function void push_result(lspd_pkg::kind_e k, logic [7:0] data, logic last,
                              logic [29:0] len, logic [7:0] rx_seq);
      lspd_pkg::result_t r;
      r.kind              = k;
      r.data_byte         = data;
      r.last              = last;
      r.message_length    = len;
      r.next_sequence     = exp_seq;
      r.received_sequence = rx_seq;
      due_results.push_back(r);
    endfunction

    // called for every word the block accepts
    function void take_word(lspd_pkg::item_t w);
      logic [31:0] total_sum;
      logic [23:0] len;
      if (w.operation == lspd_pkg::OP_SET_SEQ) begin
        exp_seq = w.new_sequence;
        halted  = 1'b0;
        clear_framing();
        return;
      end
      if (halted) return;
      if (in_payload) begin
        bytes_left = bytes_left - 24'd1;
        if (bytes_left == '0) begin
          in_payload = 1'b0;
          hdr_pos    = '0;
          frag_len   = '0;
          if (final_frag) begin
            push_result(lspd_pkg::KIND_PAYLOAD, w.link_byte, 1'b1, msg_total, '0);
            msg_total = '0;
            return;
          end
        end
        push_result(lspd_pkg::KIND_PAYLOAD, w.link_byte, 1'b0, '0, '0);
        return;
      end
      if (hdr_pos != 2'd3) begin
        frag_len = frag_len | (24'(w.link_byte) << (8 * hdr_pos));
        hdr_pos++;
        return;
      end
      // sequence byte of the header
      hdr_pos = '0;
      if (w.link_byte != exp_seq) begin
        halted = 1'b1;
        push_result(lspd_pkg::KIND_SEQ_MISMATCH, '0, 1'b0, '0, w.link_byte);
        return;
      end
      exp_seq++;
      total_sum = 32'(msg_total) + 32'(frag_len);
      len       = frag_len;
      frag_len  = '0;
      if (total_sum > 32'(lspd_pkg::HARD_MESSAGE_LIMIT)) begin
        halted = 1'b1;
        push_result(lspd_pkg::KIND_HARD_LARGE, '0, 1'b0, '0, '0);
        return;
      end
      if (total_sum > 32'(size_limit)) begin
        halted = 1'b1;
        push_result(lspd_pkg::KIND_OVER_LIMIT, '0, 1'b0, '0, '0);
        return;
      end
      msg_total  = total_sum[29:0];
      final_frag = (len < lspd_pkg::FRAGMENT_MAX);
      if (len == '0) begin
        push_result(lspd_pkg::KIND_EMPTY_END, '0, 1'b1, msg_total, '0);
        msg_total = '0;
        return;
      end
      in_payload = 1'b1;
      bytes_left = len;
    endfunction

    function void flag(string field, logic [31:0] want, logic [31:0] got);
      if (fail_count < 100)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      fail_count++;
    endfunction

    function void match_result(lspd_pkg::result_t r);
      lspd_pkg::result_t e;
      if (due_results.size() == 0) begin
        if (fail_count < 100)
          $display("%0t: stray result word, expected none, actual kind %0d data %0h",
                   $time, r.kind, r.data_byte);
        fail_count++;
        return;
      end
      e = due_results.pop_front();
      if (r.kind !== e.kind) flag("kind", e.kind, r.kind);
      if (r.data_byte !== e.data_byte) flag("data_byte", e.data_byte, r.data_byte);
      if (r.last !== e.last) flag("last", e.last, r.last);
      if (r.message_length !== e.message_length)
        flag("message_length", e.message_length, r.message_length);
      if (r.next_sequence !== e.next_sequence)
        flag("next_sequence", e.next_sequence, r.next_sequence);
      if (r.received_sequence !== e.received_sequence)
        flag("received_sequence", e.received_sequence, r.received_sequence);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic        operation_i    = lspd_pkg::OP_LINK_BYTE;
  logic [7:0]  link_byte_i    = '0;
  logic [7:0]  new_sequence_i = '0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [2:0]  kind_o;
  logic [7:0]  data_byte_o;
  logic        last_o;
  logic [29:0] message_length_o;
  logic [7:0]  next_sequence_o;
  logic [7:0]  received_sequence_o;
  logic        cfg_we_i       = 1'b0;
  logic [30:0] cfg_wdata_i    = '0;

  deframer_scoreboard sb = new();
  int      word_count = 0;
  int      hold_left  = 0;
  bit      want_hold  = 1'b0;
  bit      calm_in    = 1'b0;
  bit      calm_out   = 1'b0;
  lspd_pkg::result_t seen;

  length_seq_packet_deframer_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .operation_i        (operation_i),
    .link_byte_i        (link_byte_i),
    .new_sequence_i     (new_sequence_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .kind_o             (kind_o),
    .data_byte_o        (data_byte_o),
    .last_o             (last_o),
    .message_length_o   (message_length_o),
    .next_sequence_o    (next_sequence_o),
    .received_sequence_o(received_sequence_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        seen.kind              = lspd_pkg::kind_e'(kind_o);
        seen.data_byte         = data_byte_o;
        seen.last              = last_o;
        seen.message_length    = message_length_o;
        seen.next_sequence     = next_sequence_o;
        seen.received_sequence = received_sequence_o;
        sb.match_result(seen);
      end
      if (want_hold) begin
        hold_left = 80;
        want_hold = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (calm_out) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < 32);
      end
    end
  end

  task automatic send_word(logic op, logic [7:0] b, logic [7:0] s);
    lspd_pkg::item_t w;
    int    gap;
    gap = 0;
    if (!calm_in && $urandom_range(99) < 32) gap = $urandom_range(1, 2);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    link_byte_i    <= b;
    new_sequence_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    w.operation    = op;
    w.link_byte    = b;
    w.new_sequence = s;
    sb.take_word(w);
    word_count++;
  endtask

  task automatic send_link(logic [7:0] b);
    send_word(lspd_pkg::OP_LINK_BYTE, b, 8'($urandom_range(255)));
  endtask

  task automatic send_seq(logic [7:0] s);
    send_word(lspd_pkg::OP_SET_SEQ, 8'($urandom_range(255)), s);
  endtask

  task automatic send_header(logic [23:0] len, logic [7:0] s);
    send_link(len[7:0]);
    send_link(len[15:8]);
    send_link(len[23:16]);
    send_link(s);
  endtask

  task automatic send_packet(int len);
    send_header(24'(len), sb.exp_seq);
    repeat (len) send_link(8'($urandom_range(255)));
  endtask

  // hold input until every predicted word is out, then let the pipe settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [30:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.size_limit = v;
  endtask

  // mostly clean packets; some bad sequence bytes, cut packets and garbage, each resynced
  task automatic random_traffic(int n_words);
    int stop;
    int pick;
    int len;
    stop = word_count + n_words;
    while (word_count < stop) begin
      pick = $urandom_range(99);
      if (sb.halted) begin
        if ($urandom_range(1)) repeat ($urandom_range(1, 3)) send_link(8'($urandom_range(255)));
        send_seq(8'($urandom_range(255)));
      end else if (pick < 70) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        send_packet(len);
      end else if (pick < 78) begin
        send_header(24'($urandom_range(0, 8)), sb.exp_seq ^ 8'($urandom_range(1, 255)));
      end else if (pick < 84) begin
        // maximum-length fragment, never finished
        send_header(lspd_pkg::FRAGMENT_MAX, sb.exp_seq);
        repeat ($urandom_range(0, 5)) send_link(8'($urandom_range(255)));
        send_seq(8'($urandom_range(255)));
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 6)) send_link(8'($urandom_range(255)));
        send_seq(8'($urandom_range(255)));
      end else if (pick < 95) begin
        len = $urandom_range(2, 12);
        send_header(24'(len), sb.exp_seq);
        repeat ($urandom_range(0, len - 1)) send_link(8'($urandom_range(255)));
        send_seq(8'($urandom_range(255)));
      end else begin
        send_seq(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty message, payload extremes, bad sequence, halt, wrap, long fragment
    send_packet(0);
    send_header(24'd2, sb.exp_seq);
    send_link(8'h00);
    send_link(8'hFF);
    send_header(24'd1, sb.exp_seq ^ 8'h80);
    send_link(8'hA5);
    send_seq(8'hFF);
    send_packet(1);
    send_header(lspd_pkg::FRAGMENT_MAX, sb.exp_seq);
    send_link(8'h5A);
    send_seq(8'h00);

    // the hard size error needs ~64 full-size fragments, out of reach here
    drain();
    write_limit(31'd1);
    random_traffic(270);

    drain();
    write_limit(31'd1073741824);
    calm_in  = 1'b1;
    calm_out = 1'b1;
    random_traffic(270);
    calm_out = 1'b0;

    // back-pressure: output held off while a long packet streams in
    drain();
    send_seq(sb.exp_seq);
    want_hold = 1'b1;
    send_packet(48);
    calm_in = 1'b0;

    drain();
    write_limit(31'($urandom_range(2, 24)));
    random_traffic(270);

    drain();
    write_limit(lspd_pkg::MAX_MSG_RESET);
    random_traffic(250);

    drain();
    write_limit(31'($urandom_range(25, 1073741824)));
    random_traffic(250);

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.due_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
